>>> rtl/i2c_master_transaction_sequencer_macros.svh
// assertion macros for the i2c master transaction sequencer
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// condition and consequence in the same cycle
`define I2CMS_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// consequence in the cycle after the condition
`define I2CMS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/i2cms_pkg.sv
// shared types and constants of the i2c master transaction sequencer
package i2cms_pkg;

	localparam int MAX_BYTES_DEF = 16;

	localparam logic [7:0] ST_MASK    = 8'hF8;
	localparam logic [7:0] ST_START   = 8'h08;
	localparam logic [7:0] ST_RSTART  = 8'h10;
	localparam logic [7:0] ST_AW_ACK  = 8'h18;
	localparam logic [7:0] ST_AR_ACK  = 8'h40;
	localparam logic [7:0] ST_DW_ACK  = 8'h28;
	localparam logic [7:0] ST_DR_ACK  = 8'h50;
	localparam logic [7:0] ST_DR_NACK = 8'h58;

	typedef enum logic [1:0] {
		OP_EXEC   = 2'd0,
		OP_EVENT  = 2'd1,
		OP_CANCEL = 2'd2,
		OP_LOAD   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_SEND    = 3'd2,
		CMD_RX_ACK  = 3'd3,
		CMD_RX_NACK = 3'd4,
		CMD_STOP    = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		RC_OK         = 3'd0,
		RC_START_FAIL = 3'd1,
		RC_ADDR_FAIL  = 3'd2,
		RC_DATA_FAIL  = 3'd3,
		RC_CANCEL     = 3'd4
	} rc_t;

	typedef enum logic [2:0] {
		PH_INIT  = 3'd0,
		PH_START = 3'd1,
		PH_ADDR  = 3'd2,
		PH_DATA  = 3'd3,
		PH_NEXT  = 3'd4,
		PH_STOP  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		REG_SLAVE_ADDRESS = 3'd0,
		REG_READ_MODE     = 3'd1,
		REG_DO_START      = 3'd2,
		REG_DO_ADDRESS    = 3'd3,
		REG_DO_STOP       = 3'd4,
		REG_BYTE_COUNT    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [6:0] slave_address;
		logic       read_mode;
		logic       do_start;
		logic       do_address;
		logic       do_stop;
		logic [4:0] byte_count;
	} cfg_t;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] bus_status;
		logic [7:0] received_byte;
		logic [3:0] load_index;
		logic [7:0] load_value;
		logic       load_ack;
	} item_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] tx_byte;
		logic       accepted;
		logic       done_res;
		rc_t        result_code;
		logic [7:0] bus_error;
		logic [4:0] bytes_done;
		logic       read_valid;
		logic [3:0] read_index;
		logic [7:0] read_byte;
	} res_t;

	typedef struct packed {
		logic       byte_en;
		logic       ack_en;
		logic [7:0] wbyte;
		logic       wack;
	} wr_t;

endpackage

>>> rtl/i2cms_cfg_if.sv
// configuration write channel
interface i2cms_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [6:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/i2cms_item_if.sv
// input item channel
interface i2cms_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] bus_status;
	logic [7:0] received_byte;
	logic [3:0] load_index;
	logic [7:0] load_value;
	logic       load_ack;

	modport source(output valid, opcode, bus_status, received_byte, load_index, load_value,
		load_ack, input ready);
	modport sink(input valid, opcode, bus_status, received_byte, load_index, load_value,
		load_ack, output ready);
endinterface

>>> rtl/i2cms_res_if.sv
// result channel
interface i2cms_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] tx_byte;
	logic       accepted;
	logic       done_res;
	logic [2:0] result_code;
	logic [7:0] bus_error;
	logic [4:0] bytes_done;
	logic       read_valid;
	logic [3:0] read_index;
	logic [7:0] read_byte;

	modport source(output valid, command, tx_byte, accepted, done_res, result_code, bus_error,
		bytes_done, read_valid, read_index, read_byte, input ready);
	modport sink(input valid, command, tx_byte, accepted, done_res, result_code, bus_error,
		bytes_done, read_valid, read_index, read_byte, output ready);
endinterface

>>> rtl/i2cms_mem.sv
// transmit byte and acknowledge flag memories with write-to-read bypass
module i2cms_mem #(
	parameter int MAX_BYTES = i2cms_pkg::MAX_BYTES_DEF,
	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	input  i2cms_pkg::wr_t  wr,
	input  logic [AW-1:0]   wr_addr,
	output logic [7:0]      rd_byte,
	output logic            rd_ack
);
	import i2cms_pkg::*;

	logic [7:0] byte_mem [MAX_BYTES];
	logic       ack_mem [MAX_BYTES];
	logic [7:0] byte_rd_q;
	logic       ack_rd_q;
	logic       byp_byte_q;
	logic       byp_ack_q;
	logic [7:0] byp_wbyte_q;
	logic       byp_wack_q;

	always_ff @(posedge clk) begin
		if (wr.byte_en) begin
			byte_mem[wr_addr] <= wr.wbyte;
		end
		if (wr.ack_en) begin
			ack_mem[wr_addr] <= wr.wack;
		end
		if (rd_en) begin
			byte_rd_q   <= byte_mem[rd_addr];
			ack_rd_q    <= ack_mem[rd_addr];
			byp_wbyte_q <= wr.wbyte;
			byp_wack_q  <= wr.wack;
		end
	end

	// a write landing on the entry being read wins over the stale array data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_byte_q <= 1'b0;
			byp_ack_q  <= 1'b0;
		end else if (rd_en) begin
			byp_byte_q <= wr.byte_en && (wr_addr == rd_addr);
			byp_ack_q  <= wr.ack_en && (wr_addr == rd_addr);
		end
	end

	assign rd_byte = byp_byte_q ? byp_wbyte_q : byte_rd_q;
	assign rd_ack  = byp_ack_q ? byp_wack_q : ack_rd_q;

endmodule

>>> rtl/i2cms_step.sv
// transaction sequencer state and per-item decision
module i2cms_step #(
	parameter int MAX_BYTES = i2cms_pkg::MAX_BYTES_DEF,
	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
	localparam int CW = $clog2(MAX_BYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s1_valid,
	input  logic              fire,
	input  i2cms_pkg::item_t  it,
	input  i2cms_pkg::cfg_t   cfg,
	input  logic [7:0]        rd_byte,
	input  logic              rd_ack,
	output i2cms_pkg::res_t   res,
	output i2cms_pkg::wr_t    wr,
	output logic [AW-1:0]     wr_addr,
	output logic [CW-1:0]     fwd_cnt,
	output logic              busy
);
	import i2cms_pkg::*;

	localparam int EW = (CW > 5) ? CW : 5;

	phase_t        phase_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	phase_t        ph;
	logic [CW-1:0] cnt;
	logic          bsy;
	logic          go;
	res_t          o;
	wr_t           w;
	logic [AW-1:0] waddr;
	logic [7:0]    st;
	logic [CW-1:0] cm1;
	logic [EW-1:0] cm1_x;
	logic [EW-1:0] eff;

	always_comb begin
		ph    = phase_q;
		cnt   = cnt_q;
		bsy   = busy_q;
		go    = 1'b0;
		o     = '0;
		w     = '0;
		waddr = AW'(it.load_index);
		st    = (it.opcode == OP_EVENT) ? (it.bus_status & ST_MASK) : 8'h00;
		cm1   = cnt_q - CW'(1);
		cm1_x = EW'(cm1);
		eff   = (EW'(cfg.byte_count) > EW'(MAX_BYTES)) ? EW'(MAX_BYTES) : EW'(cfg.byte_count);

		unique case (it.opcode)
			OP_EXEC: begin
				if (!busy_q) begin
					o.accepted = 1'b1;
					cnt        = '0;
					ph         = PH_INIT;
					go         = 1'b1;
				end
			end
			OP_EVENT: begin
				go = busy_q;
			end
			OP_CANCEL: begin
				if (busy_q) begin
					o.command     = CMD_STOP;
					o.done_res    = 1'b1;
					o.result_code = RC_CANCEL;
				end
				bsy = 1'b0;
			end
			OP_LOAD: begin
				if (32'(it.load_index) < MAX_BYTES) begin
					w.byte_en = 1'b1;
					w.ack_en  = 1'b1;
					w.wbyte   = it.load_value;
					w.wack    = it.load_ack;
				end
			end
			default: ;
		endcase

		if (go && ph == PH_INIT) begin
			bsy = 1'b1;
			ph  = PH_START;
			if (cfg.do_start) begin
				o.command = CMD_START;
				go        = 1'b0;
			end
		end

		if (go && ph == PH_START) begin
			if (cfg.do_start && st != ST_START && st != ST_RSTART) begin
				bsy           = 1'b0;
				o.done_res    = 1'b1;
				o.result_code = RC_START_FAIL;
				o.bus_error   = st;
				go            = 1'b0;
			end else begin
				ph = PH_ADDR;
				if (cfg.do_address) begin
					o.command = CMD_SEND;
					o.tx_byte = {cfg.slave_address, cfg.read_mode};
					go        = 1'b0;
				end
			end
		end

		if (go && ph == PH_ADDR) begin
			if (cfg.do_address &&
				(cfg.read_mode ? (st != ST_AR_ACK) : (st != ST_AW_ACK))) begin
				bsy           = 1'b0;
				o.done_res    = 1'b1;
				o.result_code = RC_ADDR_FAIL;
				o.bus_error   = st;
				go            = 1'b0;
			end else begin
				ph  = PH_NEXT;
				cnt = '0;
			end
		end

		if (go && ph == PH_DATA) begin
			if (cfg.read_mode ? (st != ST_DR_ACK && st != ST_DR_NACK) : (st != ST_DW_ACK)) begin
				bsy           = 1'b0;
				o.done_res    = 1'b1;
				o.result_code = RC_DATA_FAIL;
				o.bus_error   = st;
				o.bytes_done  = cm1_x[4:0];
				go            = 1'b0;
			end else begin
				if (cfg.read_mode) begin
					w.byte_en    = 1'b1;
					w.wbyte      = it.received_byte;
					waddr        = AW'(cm1);
					o.read_valid = 1'b1;
					o.read_index = cm1_x[3:0];
					o.read_byte  = it.received_byte;
				end
				ph = PH_NEXT;
			end
		end

		if (go && ph == PH_NEXT) begin
			if (EW'(cnt) < eff) begin
				cnt = cnt + CW'(1);
				ph  = PH_DATA;
				go  = 1'b0;
				if (!cfg.read_mode) begin
					o.command = CMD_SEND;
					o.tx_byte = rd_byte;
				end else begin
					o.command = rd_ack ? CMD_RX_ACK : CMD_RX_NACK;
				end
			end else begin
				ph = PH_STOP;
			end
		end

		if (go && !(ph == PH_INIT || ph == PH_START || ph == PH_ADDR ||
			ph == PH_DATA || ph == PH_NEXT)) begin
			if (cfg.do_stop) begin
				o.command = CMD_STOP;
			end
			bsy        = 1'b0;
			o.done_res = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= ph;
			cnt_q   <= cnt;
			busy_q  <= bsy;
		end
	end

	always_comb begin
		res        = o;
		wr         = w;
		wr.byte_en = w.byte_en && fire;
		wr.ack_en  = w.ack_en && fire;
		wr_addr    = waddr;
	end

	assign fwd_cnt = s1_valid ? cnt : cnt_q;
	assign busy    = busy_q;

endmodule

>>> rtl/i2c_master_transaction_sequencer.sv
// top level of the i2c master transaction sequencer
//
//   channel  modport  moves
//   cfg      sink     register writes, index and data
//   evt      sink     items: execute, bus status event, cancel, buffer load
//   res      source   one result per item: command, completion, received byte
//
// one item per cycle sustained while results are taken; a result is registered after the decide stage
// the transfer reads the byte memory at the pending byte counter, the decide stage decides
// back-to-back items on the same entry are bypassed around the memory
// reset clears phase, counter and busy and sets config to its defaults; buffer contents stay undefined
// a stalled result holds the decide stage, and the input stalls behind it
`include "i2c_master_transaction_sequencer_macros.svh"

module i2c_master_transaction_sequencer #(
	parameter int MAX_BYTES = i2cms_pkg::MAX_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	i2cms_cfg_if.sink  cfg,
	i2cms_item_if.sink evt,
	i2cms_res_if.source res
);
	import i2cms_pkg::*;

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CW = $clog2(MAX_BYTES + 1);

	cfg_t          cfg_q;
	item_t         item_s1;
	logic          s1_valid_q;
	res_t          res_q;
	logic          res_valid_q;

	logic          accept;
	logic          s1_fire;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_byte;
	logic          rd_ack;
	res_t          step_res;
	wr_t           wr;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] fwd_cnt;
	logic          busy;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address <= '0;
			cfg_q.read_mode     <= 1'b0;
			cfg_q.do_start      <= 1'b1;
			cfg_q.do_address    <= 1'b1;
			cfg_q.do_stop       <= 1'b1;
			cfg_q.byte_count    <= '0;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_SLAVE_ADDRESS: cfg_q.slave_address <= cfg.data;
				REG_READ_MODE:     cfg_q.read_mode     <= cfg.data[0];
				REG_DO_START:      cfg_q.do_start      <= cfg.data[0];
				REG_DO_ADDRESS:    cfg_q.do_address    <= cfg.data[0];
				REG_DO_STOP:       cfg_q.do_stop       <= cfg.data[0];
				REG_BYTE_COUNT:    cfg_q.byte_count    <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	assign s1_fire   = s1_valid_q && (!res_valid_q || res.ready);
	assign evt.ready = !s1_valid_q || s1_fire;
	assign accept    = evt.valid && evt.ready;
	assign rd_addr   = (opcode_t'(evt.opcode) == OP_EXEC) ? '0 : fwd_cnt[AW-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode        <= opcode_t'(evt.opcode);
			item_s1.bus_status    <= evt.bus_status;
			item_s1.received_byte <= evt.received_byte;
			item_s1.load_index    <= evt.load_index;
			item_s1.load_value    <= evt.load_value;
			item_s1.load_ack      <= evt.load_ack;
		end
		if (s1_fire) begin
			res_q <= step_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	i2cms_mem #(
		.MAX_BYTES(MAX_BYTES)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_byte (rd_byte),
		.rd_ack  (rd_ack)
	);

	i2cms_step #(
		.MAX_BYTES(MAX_BYTES)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid_q),
		.fire     (s1_fire),
		.it       (item_s1),
		.cfg      (cfg_q),
		.rd_byte  (rd_byte),
		.rd_ack   (rd_ack),
		.res      (step_res),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.fwd_cnt  (fwd_cnt),
		.busy     (busy)
	);

	assign res.valid       = res_valid_q;
	assign res.command     = res_q.command;
	assign res.tx_byte     = res_q.tx_byte;
	assign res.accepted    = res_q.accepted;
	assign res.done_res    = res_q.done_res;
	assign res.result_code = res_q.result_code;
	assign res.bus_error   = res_q.bus_error;
	assign res.bytes_done  = res_q.bytes_done;
	assign res.read_valid  = res_q.read_valid;
	assign res.read_index  = res_q.read_index;
	assign res.read_byte   = res_q.read_byte;

	`I2CMS_ASSERT_NEXT(a_done_idle, s1_fire && step_res.done_res, !busy, "busy after done")
	`I2CMS_ASSERT_NEXT(a_start_busy, s1_fire && step_res.accepted && !step_res.done_res,
		busy, "idle after start")
	`I2CMS_ASSERT_NOW(a_rd_mode, res.valid && res.read_valid, cfg_q.read_mode, "read outside read mode")
	`I2CMS_ASSERT_NOW(a_stall, !evt.ready, s1_valid_q && res_valid_q && !res.ready,
		"input stall unexplained")

endmodule

>>> dv/i2c_master_transaction_sequencer_tb.sv
// testbench for the i2c master transaction sequencer with an in-bench sequencer model
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_tb;
	import i2cms_pkg::*;

	localparam int BUF_DEPTH = MAX_BYTES_DEF;
	localparam int PIPE_LAT = 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1550;

	logic clk;
	logic arst_n;

	i2cms_cfg_if  cfg_ch();
	i2cms_item_if item_ch();
	i2cms_res_if  res_ch();

	i2c_master_transaction_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.evt(item_ch),
		.res(res_ch)
	);

	// sequencer model state
	cfg_t       shadow_cfg;
	phase_t     seq_phase;
	logic [4:0] seq_count;
	logic       seq_busy;
	logic [7:0] tx_mem [BUF_DEPTH];
	logic       ack_mem [BUF_DEPTH];

	res_t        issued_cmds [$];
	int          mismatches;
	int          results_checked;
	int          worked_items;
	int          bytes_rx;
	int          done_by_rc [5];
	int unsigned cycle_count;
	int          src_gap_pct;
	int          sink_stall_pct;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				issued_cmds.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

	task automatic flag_mismatch(input string what, input logic [31:0] got_v,
		input logic [31:0] want_v);
		if (mismatches < 40)
			$display("mismatch at result %0d: %s got %0h want %0h", results_checked, what,
				got_v, want_v);
		mismatches++;
	endtask

	function automatic void close_transaction(inout res_t r, input rc_t code,
		input logic [7:0] err, input logic [4:0] n);
		seq_busy = 1'b0;
		r.done_res = 1'b1;
		r.result_code = code;
		r.bus_error = err;
		r.bytes_done = n;
	endfunction

	// walks the phases until a bus command is issued or the transaction ends
	function automatic void run_sequence(input logic [7:0] st, input logic [7:0] rx,
		inout res_t r);
		logic [4:0] span;
		logic [3:0] k;
		bit         settled;
		span = (shadow_cfg.byte_count > BUF_DEPTH) ? 5'(BUF_DEPTH) : shadow_cfg.byte_count;
		settled = 1'b0;
		while (!settled) begin
			case (seq_phase)
				PH_INIT: begin
					seq_busy = 1'b1;
					seq_phase = PH_START;
					if (shadow_cfg.do_start) begin
						r.command = CMD_START;
						settled = 1'b1;
					end
				end
				PH_START: begin
					if (shadow_cfg.do_start && st != ST_START && st != ST_RSTART) begin
						close_transaction(r, RC_START_FAIL, st, 5'd0);
						settled = 1'b1;
					end else begin
						seq_phase = PH_ADDR;
						if (shadow_cfg.do_address) begin
							r.command = CMD_SEND;
							r.tx_byte = {shadow_cfg.slave_address, shadow_cfg.read_mode};
							settled = 1'b1;
						end
					end
				end
				PH_ADDR: begin
					if (shadow_cfg.do_address &&
						(shadow_cfg.read_mode ? st != ST_AR_ACK : st != ST_AW_ACK)) begin
						close_transaction(r, RC_ADDR_FAIL, st, 5'd0);
						settled = 1'b1;
					end else begin
						seq_phase = PH_NEXT;
						seq_count = 5'd0;
					end
				end
				PH_DATA: begin
					if (shadow_cfg.read_mode ? (st != ST_DR_ACK && st != ST_DR_NACK) :
						st != ST_DW_ACK) begin
						close_transaction(r, RC_DATA_FAIL, st, seq_count - 5'd1);
						settled = 1'b1;
					end else begin
						if (shadow_cfg.read_mode) begin
							k = 4'(seq_count - 5'd1);
							tx_mem[k] = rx;
							r.read_valid = 1'b1;
							r.read_index = k;
							r.read_byte = rx;
						end
						seq_phase = PH_NEXT;
					end
				end
				PH_NEXT: begin
					if (seq_count < span) begin
						k = seq_count[3:0];
						seq_count = seq_count + 5'd1;
						seq_phase = PH_DATA;
						if (!shadow_cfg.read_mode) begin
							r.command = CMD_SEND;
							r.tx_byte = tx_mem[k];
						end else begin
							r.command = ack_mem[k] ? CMD_RX_ACK : CMD_RX_NACK;
						end
						settled = 1'b1;
					end else begin
						seq_phase = PH_STOP;
					end
				end
				default: begin
					if (shadow_cfg.do_stop)
						r.command = CMD_STOP;
					close_transaction(r, RC_OK, 8'h00, 5'd0);
					settled = 1'b1;
				end
			endcase
		end
	endfunction

	function automatic res_t next_bus_step(input item_t it);
		res_t r;
		r = '0;
		case (it.opcode)
			OP_EXEC: begin
				if (!seq_busy) begin
					r.accepted = 1'b1;
					seq_count = 5'd0;
					seq_phase = PH_INIT;
					run_sequence(8'h00, 8'h00, r);
				end
			end
			OP_EVENT: begin
				if (seq_busy)
					run_sequence(it.bus_status & ST_MASK, it.received_byte, r);
			end
			OP_CANCEL: begin
				if (seq_busy) begin
					r.command = CMD_STOP;
					close_transaction(r, RC_CANCEL, 8'h00, 5'd0);
				end
				seq_busy = 1'b0;
			end
			default: begin
				tx_mem[it.load_index] = it.load_value;
				ack_mem[it.load_index] = it.load_ack;
			end
		endcase
		return r;
	endfunction

	// model update on every transfer, then result check
	always @(posedge clk or negedge arst_n) begin
		item_t seen;
		res_t  got;
		res_t  want;
		if (!arst_n) begin
			shadow_cfg.slave_address = 7'd0;
			shadow_cfg.read_mode = 1'b0;
			shadow_cfg.do_start = 1'b1;
			shadow_cfg.do_address = 1'b1;
			shadow_cfg.do_stop = 1'b1;
			shadow_cfg.byte_count = 5'd0;
			seq_phase = PH_INIT;
			seq_count = 5'd0;
			seq_busy = 1'b0;
			issued_cmds.delete();
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_SLAVE_ADDRESS: shadow_cfg.slave_address = cfg_ch.data;
					REG_READ_MODE:     shadow_cfg.read_mode = cfg_ch.data[0];
					REG_DO_START:      shadow_cfg.do_start = cfg_ch.data[0];
					REG_DO_ADDRESS:    shadow_cfg.do_address = cfg_ch.data[0];
					REG_DO_STOP:       shadow_cfg.do_stop = cfg_ch.data[0];
					REG_BYTE_COUNT:    shadow_cfg.byte_count = cfg_ch.data[4:0];
					default: ;
				endcase
			end
			if (item_ch.valid && item_ch.ready) begin
				seen.opcode = opcode_t'(item_ch.opcode);
				seen.bus_status = item_ch.bus_status;
				seen.received_byte = item_ch.received_byte;
				seen.load_index = item_ch.load_index;
				seen.load_value = item_ch.load_value;
				seen.load_ack = item_ch.load_ack;
				if (seen.opcode == OP_LOAD || (seen.opcode == OP_EXEC) != seq_busy)
					worked_items++;
				want = next_bus_step(seen);
				if (want.done_res)
					done_by_rc[want.result_code]++;
				if (want.read_valid)
					bytes_rx++;
				issued_cmds.push_back(want);
			end
			if (res_ch.valid && res_ch.ready) begin
				got.command = cmd_t'(res_ch.command);
				got.tx_byte = res_ch.tx_byte;
				got.accepted = res_ch.accepted;
				got.done_res = res_ch.done_res;
				got.result_code = rc_t'(res_ch.result_code);
				got.bus_error = res_ch.bus_error;
				got.bytes_done = res_ch.bytes_done;
				got.read_valid = res_ch.read_valid;
				got.read_index = res_ch.read_index;
				got.read_byte = res_ch.read_byte;
				if (issued_cmds.size() == 0) begin
					flag_mismatch("result with nothing pending, command", got.command, 0);
				end else begin
					want = issued_cmds.pop_front();
					if (got.command !== want.command)
						flag_mismatch("command", got.command, want.command);
					if (got.tx_byte !== want.tx_byte)
						flag_mismatch("tx_byte", got.tx_byte, want.tx_byte);
					if (got.accepted !== want.accepted)
						flag_mismatch("accepted", got.accepted, want.accepted);
					if (got.done_res !== want.done_res)
						flag_mismatch("done_res", got.done_res, want.done_res);
					if (got.result_code !== want.result_code)
						flag_mismatch("result_code", got.result_code, want.result_code);
					if (got.bus_error !== want.bus_error)
						flag_mismatch("bus_error", got.bus_error, want.bus_error);
					if (got.bytes_done !== want.bytes_done)
						flag_mismatch("bytes_done", got.bytes_done, want.bytes_done);
					if (got.read_valid !== want.read_valid)
						flag_mismatch("read_valid", got.read_valid, want.read_valid);
					if (got.read_index !== want.read_index)
						flag_mismatch("read_index", got.read_index, want.read_index);
					if (got.read_byte !== want.read_byte)
						flag_mismatch("read_byte", got.read_byte, want.read_byte);
				end
				results_checked++;
			end
		end
	end

	// driving tasks are entered and left at a falling edge
	task automatic send_item(input item_t it);
		while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= it.opcode;
		item_ch.bus_status <= it.bus_status;
		item_ch.received_byte <= it.received_byte;
		item_ch.load_index <= it.load_index;
		item_ch.load_value <= it.load_value;
		item_ch.load_ack <= it.load_ack;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	function automatic item_t rand_item(input opcode_t op);
		item_t it;
		it.opcode = op;
		it.bus_status = 8'($urandom);
		it.received_byte = 8'($urandom);
		it.load_index = 4'($urandom);
		it.load_value = 8'($urandom);
		it.load_ack = 1'($urandom);
		return it;
	endfunction

	task automatic do_exec();
		send_item(rand_item(OP_EXEC));
	endtask

	task automatic do_cancel();
		send_item(rand_item(OP_CANCEL));
	endtask

	task automatic do_event(input logic [7:0] st, input logic [7:0] rx);
		item_t it;
		it = rand_item(OP_EVENT);
		it.bus_status = st;
		it.received_byte = rx;
		send_item(it);
	endtask

	task automatic do_load(input logic [3:0] idx, input logic [7:0] val, input logic ack);
		item_t it;
		it = rand_item(OP_LOAD);
		it.load_index = idx;
		it.load_value = val;
		it.load_ack = ack;
		send_item(it);
	endtask

	// holds the sender until every pending result has come out
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (issued_cmds.size() != 0) @(negedge clk);
		repeat (PIPE_LAT) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [6:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// status the bus engine would return for the command just issued, junk in the low bits
	function automatic logic [7:0] proper_status();
		logic [7:0] s;
		case (seq_phase)
			PH_START: s = $urandom_range(1) ? ST_START : ST_RSTART;
			PH_ADDR:  s = shadow_cfg.read_mode ? ST_AR_ACK : ST_AW_ACK;
			PH_DATA:  s = shadow_cfg.read_mode ? ($urandom_range(1) ? ST_DR_ACK : ST_DR_NACK) :
				ST_DW_ACK;
			default:  s = 8'($urandom);
		endcase
		return s | 8'($urandom_range(7));
	endfunction

	task automatic test_buffer_fill();
		logic [7:0] val;
		for (int i = 0; i < BUF_DEPTH; i++) begin
			val = (i == 0) ? 8'h00 : (i == BUF_DEPTH - 1) ? 8'hFF : 8'($urandom);
			do_load(4'(i), val, 1'(i));
		end
	endtask

	task automatic test_idle_items();
		do_event(8'hFF, 8'hFF);
		do_cancel();
	endtask

	task automatic test_default_write();
		do_exec();
		do_event(ST_START | 8'h07, 8'h00);
		do_event(ST_AW_ACK, 8'hFF);
	endtask

	// read with both data statuses, busy execute, load during transfer, stop dropped mid-way
	task automatic test_read_live_settings();
		drain();
		write_reg(REG_SLAVE_ADDRESS, 7'h7F);
		write_reg(REG_READ_MODE, 7'd1);
		write_reg(REG_BYTE_COUNT, 7'd2);
		do_exec();
		do_event(ST_RSTART, 8'h00);
		do_event(ST_AR_ACK, 8'h00);
		do_exec();
		do_load(4'd1, 8'h5A, 1'b1);
		do_event(ST_DR_NACK, 8'hFF);
		drain();
		write_reg(REG_DO_STOP, 7'd0);
		do_event(ST_DR_ACK, 8'h00);
	endtask

	// count above the buffer depth saturates; sends bytes received just before, then cancel
	task automatic test_saturation_cancel();
		drain();
		write_reg(REG_READ_MODE, 7'd0);
		write_reg(REG_DO_START, 7'd0);
		write_reg(REG_DO_ADDRESS, 7'd0);
		write_reg(REG_DO_STOP, 7'd1);
		write_reg(REG_BYTE_COUNT, 7'd20);
		do_exec();
		do_event(ST_DW_ACK, 8'h00);
		do_cancel();
	endtask

	task automatic test_start_fail();
		drain();
		write_reg(REG_DO_START, 7'd1);
		do_exec();
		do_event(8'hF8, 8'h00);
	endtask

	task automatic random_settings();
		int         p;
		logic [6:0] n;
		drain();
		p = $urandom_range(3);
		if (p == 0)
			write_reg(REG_SLAVE_ADDRESS, 7'h00);
		else if (p == 1)
			write_reg(REG_SLAVE_ADDRESS, 7'h7F);
		else
			write_reg(REG_SLAVE_ADDRESS, 7'($urandom));
		write_reg(REG_READ_MODE, 7'($urandom_range(1)));
		write_reg(REG_DO_START, 7'($urandom_range(4) != 0));
		write_reg(REG_DO_ADDRESS, 7'($urandom_range(4) != 0));
		write_reg(REG_DO_STOP, 7'($urandom_range(4) != 0));
		p = $urandom_range(99);
		if (p < 60)
			n = 7'($urandom_range(4));
		else if (p < 75)
			n = 7'($urandom_range(15, 5));
		else if (p < 90)
			n = 7'(BUF_DEPTH);
		else
			n = 7'($urandom_range(31, 17));
		write_reg(REG_BYTE_COUNT, n);
	endtask

	task automatic random_transaction();
		int pick;
		do_exec();
		while (seq_busy) begin
			pick = $urandom_range(199);
			if (pick < 170)
				do_event(proper_status(), 8'($urandom));
			else if (pick < 178)
				do_event(8'($urandom), 8'($urandom));
			else if (pick < 184)
				do_exec();
			else if (pick < 192)
				do_load(4'($urandom), 8'($urandom), 1'($urandom));
			else if (pick < 196)
				do_cancel();
			else
				drain();
		end
	endtask

	task automatic test_random_traffic();
		int goal;
		int pick;
		int m;
		for (m = 0; m < 3; m++) begin
			src_gap_pct = (m == 0) ? 16 : (m == 1) ? 49 : 0;
			sink_stall_pct = (m == 0) ? 49 : (m == 1) ? 16 : 0;
			goal = worked_items + RANDOM_ITEMS / 3;
			while (worked_items < goal) begin
				random_settings();
				repeat (6) begin
					pick = $urandom_range(9);
					if (pick == 0)
						do_event(8'($urandom), 8'($urandom));
					else if (pick == 1)
						do_cancel();
					else if (pick == 2)
						do_load(4'($urandom), 8'($urandom), 1'($urandom));
					random_transaction();
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = '0;
		item_ch.bus_status = '0;
		item_ch.received_byte = '0;
		item_ch.load_index = '0;
		item_ch.load_value = '0;
		item_ch.load_ack = 1'b0;
		res_ch.ready = 1'b0;
		src_gap_pct = 0;
		sink_stall_pct = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_buffer_fill();
		test_idle_items();
		test_default_write();
		test_read_live_settings();
		test_saturation_cancel();
		test_start_fail();
		test_random_traffic();

		drain();
		repeat (6) @(negedge clk);
		if (issued_cmds.size() != 0)
			flag_mismatch("results never delivered", issued_cmds.size(), 0);
		$display("covered %0d working items, %0d results checked, %0d bytes received",
			worked_items, results_checked, bytes_rx);
		$display("endings: ok %0d, start fail %0d, address fail %0d, data fail %0d, cancel %0d",
			done_by_rc[RC_OK], done_by_rc[RC_START_FAIL], done_by_rc[RC_ADDR_FAIL],
			done_by_rc[RC_DATA_FAIL], done_by_rc[RC_CANCEL]);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
